>>> hdl/osl_pkg.sv
package osl_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        section_is_data;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_SEC_ADDR   = 4'd1,
        PH_SEC_COUNT  = 4'd2,
        PH_SEC_WORDS  = 4'd3,
        PH_SYM_ADDR   = 4'd4,
        PH_SYM_COUNT  = 4'd5,
        PH_FN_COUNT   = 4'd6,
        PH_SKIP_BYTES = 4'd7
    } t_phase;

    typedef enum logic {
        CMD_SET_ADDR = 1'b0,
        CMD_WRITE    = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] word;
        logic        is_data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_push;

    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;
    localparam logic [15:0] HDR_FNAME  = 16'hF17E;
    localparam logic [15:0] HDR_LINE   = 16'h715E;
    localparam logic [15:0] LINE_SKIP  = 16'd6;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

endpackage

>>> hdl/osl_front.sv
module osl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  osl_pkg::t_in_item i_item,
    output osl_pkg::t_cmd_push o_push
);
    import osl_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_high, n_high;
    logic        r_byte_sel, n_byte_sel;
    logic [15:0] r_count, n_count;
    logic        r_is_data, n_is_data;

    t_phase      cur_phase;
    logic [7:0]  cur_high;
    logic        cur_sel;
    logic [15:0] cur_count;
    logic        cur_data;
    logic [15:0] word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_high     <= 8'd0;
            r_byte_sel <= 1'b0;
            r_count    <= 16'd0;
            r_is_data  <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_high     <= n_high;
            r_byte_sel <= n_byte_sel;
            r_count    <= n_count;
            r_is_data  <= n_is_data;
        end
    end

    always_comb begin
        // file_start drops any parse in progress before this byte is used
        cur_phase = i_item.file_start ? PH_HEADER : r_phase;
        cur_high  = i_item.file_start ? 8'd0 : r_high;
        cur_sel   = i_item.file_start ? 1'b0 : r_byte_sel;
        cur_count = i_item.file_start ? 16'd0 : r_count;
        cur_data  = i_item.file_start ? 1'b0 : r_is_data;
        word      = {cur_high, i_item.data_byte};

        n_phase    = cur_phase;
        n_high     = cur_high;
        n_byte_sel = cur_sel;
        n_count    = cur_count;
        n_is_data  = cur_data;

        o_push.valid       = 1'b0;
        o_push.cmd.kind    = CMD_WRITE;
        o_push.cmd.word    = word;
        o_push.cmd.is_data = cur_data;

        if (cur_phase == PH_SKIP_BYTES) begin
            n_count = cur_count - 16'd1;
            if (n_count == 16'd0) begin
                n_phase = PH_HEADER;
            end
        end else if (!cur_sel) begin
            n_high     = i_item.data_byte;
            n_byte_sel = 1'b1;
        end else begin
            n_byte_sel = 1'b0;
            case (cur_phase)
                PH_SEC_ADDR: begin
                    o_push.valid    = i_accept;
                    o_push.cmd.kind = CMD_SET_ADDR;
                    n_phase         = PH_SEC_COUNT;
                end
                PH_SEC_COUNT: begin
                    n_count = word;
                    n_phase = (word == 16'd0) ? PH_HEADER : PH_SEC_WORDS;
                end
                PH_SEC_WORDS: begin
                    o_push.valid = i_accept;
                    n_count      = cur_count - 16'd1;
                    if (n_count == 16'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_SYM_ADDR: begin
                    n_phase = PH_SYM_COUNT;
                end
                PH_SYM_COUNT, PH_FN_COUNT: begin
                    n_count = word;
                    n_phase = (word == 16'd0) ? PH_HEADER : PH_SKIP_BYTES;
                end
                default: begin
                    if (word == HDR_CODE || word == HDR_DATA) begin
                        n_is_data = (word == HDR_DATA);
                        n_phase   = PH_SEC_ADDR;
                    end else if (word == HDR_SYMBOL) begin
                        n_phase = PH_SYM_ADDR;
                    end else if (word == HDR_FNAME) begin
                        n_phase = PH_FN_COUNT;
                    end else if (word == HDR_LINE) begin
                        n_count = LINE_SKIP;
                        n_phase = PH_SKIP_BYTES;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/osl_cmd_fifo.sv
module osl_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  osl_pkg::t_cmd_push i_push,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output osl_pkg::t_cmd      o_head
);
    import osl_pkg::*;

    t_cmd            r_mem [CMD_DEPTH];
    logic [CMD_AW:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_AW:0] r_rd_ptr, n_rd_ptr;

    always_comb begin
        o_empty  = (r_wr_ptr == r_rd_ptr);
        o_full   = (r_wr_ptr[CMD_AW] != r_rd_ptr[CMD_AW])
                && (r_wr_ptr[CMD_AW-1:0] == r_rd_ptr[CMD_AW-1:0]);
        o_head   = r_mem[r_rd_ptr[CMD_AW-1:0]];
        n_wr_ptr = (i_push.valid && !o_full) ? r_wr_ptr + {{CMD_AW{1'b0}}, 1'b1} : r_wr_ptr;
        n_rd_ptr = (i_pop && !o_empty) ? r_rd_ptr + {{CMD_AW{1'b0}}, 1'b1} : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid && !o_full) begin
            r_mem[r_wr_ptr[CMD_AW-1:0]] <= i_push.cmd;
        end
    end

endmodule

>>> hdl/osl_back.sv
module osl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  osl_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    input  logic               i_pop,
    output logic               o_empty,
    output osl_pkg::t_out_item o_item
);
    import osl_pkg::*;

    logic [15:0] r_addr, n_addr;
    logic        r_is_data, n_is_data;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    always_comb begin
        // take a command when the output word slot is free or drains now
        o_cmd_take  = i_cmd_valid && (!r_out_valid || i_pop);
        n_addr      = r_addr;
        n_is_data   = r_is_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        if (o_cmd_take) begin
            case (i_cmd.kind)
                CMD_SET_ADDR: begin
                    n_addr    = i_cmd.word;
                    n_is_data = i_cmd.is_data;
                end
                CMD_WRITE: begin
                    n_out.write_address   = r_addr;
                    n_out.write_data      = i_cmd.word;
                    n_out.section_is_data = r_is_data;
                    n_out_valid           = 1'b1;
                    n_addr                = r_addr + 16'd1;
                end
                default: begin
                    n_addr = r_addr;
                end
            endcase
        end
        o_empty = !r_out_valid;
        o_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_addr      <= 16'd0;
            r_is_data   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_is_data   <= n_is_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

>>> hdl/object_file_section_loader.sv
// Object file section loader. Bytes arrive on the push side, one per cycle while full
// is low, and are paired into 16-bit words high byte first; code and data sections come
// out as memory writes (address, word, data flag) on the pop side, in file order. A
// write word goes from the parser into the command queue and from there into the
// result register, which drives the result ports; it waits in the queue while the
// result register holds a word that is not being popped. The parser hands address and
// write commands to a four-entry queue; a command leaves it only while the result
// register is free or being popped, so full rises only once that queue fills, which
// happens only while results are not being popped.
module object_file_section_loader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  osl_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output osl_pkg::t_out_item o_out_item
);
    import osl_pkg::*;

    t_cmd_push front_push;
    t_cmd      fifo_head;
    logic      fifo_empty;
    logic      cmd_take;
    logic      accept;

    assign accept = push && !full;

    osl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (front_push)
    );

    osl_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pop   (cmd_take),
        .o_full  (full),
        .o_empty (fifo_empty),
        .o_head  (fifo_head)
    );

    osl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!fifo_empty),
        .i_cmd       (fifo_head),
        .o_cmd_take  (cmd_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

>>> hdl/osl_checker.sv
module osl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input osl_pkg::t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full after reset");

    // the queue only fills when a byte was taken on the previous edge
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an accepted byte");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result word changed or vanished");

endmodule

bind object_file_section_loader osl_checker u_osl_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import osl_pkg::*;

    localparam int RAND_ITEMS   = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } row_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    object_file_section_loader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    t_phase      st_phase;
    logic [7:0]  st_high;
    logic        st_low_next;
    logic [15:0] st_addr;
    logic [15:0] st_remain;
    logic        st_is_data;

    t_out_item expected_writes[$];
    t_in_item  file_bytes[$];
    row_t      dir_rows[$];

    int  err_count   = 0;
    int  idle_cycles = 0;
    int  burst_left  = 0;
    int  rand_sent   = 0;
    int  holds       = 0;
    bit  hold_req    = 1'b0;
    int  rx_cycle    = 0;
    int  rx_mode     = 0;
    t_out_item got_write;
    t_out_item want_write;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < MAX_PRINTED)
            $display("ERROR %s: got %h, want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    function automatic void clear_parse_state();
        st_phase    = PH_HEADER;
        st_high     = 8'd0;
        st_low_next = 1'b0;
        st_addr     = 16'd0;
        st_remain   = 16'd0;
        st_is_data  = 1'b0;
    endfunction

    // one byte through the parser; has is set when a memory write comes out
    task automatic loader_step(input t_in_item it, output bit has, output t_out_item wr);
        logic [15:0] w;
        has = 1'b0;
        wr  = '0;
        if (it.file_start)
            clear_parse_state();
        if (st_phase == PH_SKIP_BYTES) begin
            st_remain = st_remain - 16'd1;
            if (st_remain == 16'd0)
                st_phase = PH_HEADER;
        end else if (!st_low_next) begin
            st_high     = it.data_byte;
            st_low_next = 1'b1;
        end else begin
            st_low_next = 1'b0;
            w = {st_high, it.data_byte};
            case (st_phase)
                PH_SEC_ADDR: begin
                    st_addr  = w;
                    st_phase = PH_SEC_COUNT;
                end
                PH_SEC_COUNT: begin
                    st_remain = w;
                    st_phase  = (w == 16'd0) ? PH_HEADER : PH_SEC_WORDS;
                end
                PH_SEC_WORDS: begin
                    has = 1'b1;
                    wr.write_address   = st_addr;
                    wr.write_data      = w;
                    wr.section_is_data = st_is_data;
                    st_addr   = st_addr + 16'd1;
                    st_remain = st_remain - 16'd1;
                    if (st_remain == 16'd0)
                        st_phase = PH_HEADER;
                end
                PH_SYM_ADDR: st_phase = PH_SYM_COUNT;
                PH_SYM_COUNT, PH_FN_COUNT: begin
                    st_remain = w;
                    st_phase  = (w == 16'd0) ? PH_HEADER : PH_SKIP_BYTES;
                end
                default: begin
                    if (w == HDR_CODE || w == HDR_DATA) begin
                        st_is_data = (w == HDR_DATA);
                        st_phase   = PH_SEC_ADDR;
                    end else if (w == HDR_SYMBOL) begin
                        st_phase = PH_SYM_ADDR;
                    end else if (w == HDR_FNAME) begin
                        st_phase = PH_FN_COUNT;
                    end else if (w == HDR_LINE) begin
                        st_remain = LINE_SKIP;
                        st_phase  = PH_SKIP_BYTES;
                    end else begin
                        st_phase = PH_HEADER;
                    end
                end
            endcase
        end
    endtask

    // offer one byte, in bursts with random gaps, and log what it should produce
    task automatic send_byte(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        bit        has;
        t_out_item wr;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(300, 100)
                                                     : $urandom_range(40, 1);
            gap = ($urandom_range(7, 0) == 0) ? $urandom_range(30, 8) : $urandom_range(4, 1);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        loader_step(it, has, wr);
        if (typed)
            expected_writes.push_back(want);
        else if (has)
            expected_writes.push_back(wr);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        t_in_item it;
        it.data_byte  = b;
        it.file_start = 1'b0;
        file_bytes.push_back(it);
    endfunction

    function automatic void add_word(input logic [15:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    // well-formed object file with random content; now and then cut short
    task automatic build_file(input bit dense);
        int          nsec;
        int          pick;
        int          n;
        int          cut;
        logic [15:0] addr;
        file_bytes.delete();
        nsec = $urandom_range(5, 1);
        for (int s = 0; s < nsec; s++) begin
            pick = dense && s == 0 ? 0 : $urandom_range(99, 0);
            if (pick < 50) begin
                add_word(($urandom_range(1, 0) == 0 || dense) ? HDR_CODE : HDR_DATA);
                addr = ($urandom_range(4, 0) == 0) ? 16'hFFF8 + 16'($urandom_range(7, 0))
                                                   : 16'($urandom_range(16'hFFFF, 0));
                add_word(addr);
                pick = $urandom_range(99, 0);
                if (dense)           n = 40;
                else if (pick < 10)  n = 0;
                else if (pick < 95)  n = $urandom_range(8, 1);
                else                 n = $urandom_range(60, 20);
                add_word(16'(n));
                cut = (!dense && n > 0 && $urandom_range(19, 0) == 0) ? $urandom_range(n - 1, 0)
                                                                      : n;
                for (int k = 0; k < cut; k++)
                    add_word(16'($urandom_range(16'hFFFF, 0)));
                if (cut != n) begin
                    // truncated mid-section: end the file here
                    if ($urandom_range(1, 0) == 0)
                        add_byte(8'($urandom_range(255, 0)));
                    break;
                end
            end else if (pick < 62) begin
                add_word(HDR_SYMBOL);
                add_word(16'($urandom_range(16'hFFFF, 0)));
                n = $urandom_range(6, 0);
                add_word(16'(n));
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom_range(255, 0)));
            end else if (pick < 74) begin
                add_word(HDR_FNAME);
                n = $urandom_range(6, 0);
                add_word(16'(n));
                for (int k = 0; k < n; k++)
                    add_byte(8'($urandom_range(255, 0)));
            end else if (pick < 86) begin
                add_word(HDR_LINE);
                for (int k = 0; k < 6; k++)
                    add_byte(8'($urandom_range(255, 0)));
            end else begin
                add_word(16'($urandom_range(16'hFFFF, 0)));
            end
        end
        if (!dense && $urandom_range(24, 0) == 0)
            add_byte(8'($urandom_range(255, 0)));
        if (dense || $urandom_range(9, 0) != 0)
            file_bytes[0].file_start = 1'b1;
    endtask

    function automatic row_t mk_row(input logic [7:0] b, input logic fs, input bit typed,
                                    input logic [15:0] addr, input logic [15:0] data,
                                    input logic is_data);
        row_t r;
        r.it.data_byte  = b;
        r.it.file_start = fs;
        r.typed         = typed;
        r.want.write_address   = addr;
        r.want.write_data      = data;
        r.want.section_is_data = is_data;
        return r;
    endfunction

    function automatic void build_directed();
        // code section at the top of memory, address wraps
        dir_rows.push_back(mk_row(8'hCA, 1'b1, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hDE, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h02, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h12, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h34, 1'b0, 1, 16'hFFFF, 16'h1234, 1'b0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 1, 16'h0000, 16'hFFFF, 1'b0));
        // file name with zero length
        dir_rows.push_back(mk_row(8'hF1, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h7E, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        // one-word data section
        dir_rows.push_back(mk_row(8'hDA, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hDA, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h10, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h01, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hAB, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hCD, 1'b0, 1, 16'h0010, 16'hABCD, 1'b1));
        // line-number header; the C3 B7 after it are skipped bytes, and the skip runs on into the next file
        dir_rows.push_back(mk_row(8'h71, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'h5E, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hC3, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
        dir_rows.push_back(mk_row(8'hB7, 1'b0, 0, 16'h0000, 16'h0000, 1'b0));
    endfunction

    // result side: compare each popped word with the oldest expected write
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            got_write = o_out_item;
            if (expected_writes.size() == 0) begin
                report_mismatch("unexpected write, address", got_write.write_address, 16'h0);
            end else begin
                want_write = expected_writes.pop_front();
                if (got_write.write_address !== want_write.write_address)
                    report_mismatch("write_address", got_write.write_address,
                                    want_write.write_address);
                if (got_write.write_data !== want_write.write_data)
                    report_mismatch("write_data", got_write.write_data, want_write.write_data);
                if (got_write.section_is_data !== want_write.section_is_data)
                    report_mismatch("section_is_data", 16'(got_write.section_is_data),
                                    16'(want_write.section_is_data));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: stall pattern is redrawn at random from four modes; long hold-off on request
    initial begin
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rx_cycle++;
            if (rx_cycle % 50 == 0)
                rx_mode = $urandom_range(3, 0);
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(1, 0));
                2: pop <= (rx_cycle % 4 == 0);
                default: pop <= (rx_cycle % 16 < 12);
            endcase
        end
    end

    initial begin
        bit dense;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_in_item <= '0;
        clear_parse_state();
        build_directed();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k])
            send_byte(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        while (rand_sent < RAND_ITEMS) begin
            dense = 1'b0;
            if ((holds == 0 && rand_sent >= 300) || (holds == 1 && rand_sent >= 1000)) begin
                // stall the receiver and push a long section so the block backs up
                holds++;
                hold_req = 1'b1;
                dense    = 1'b1;
            end
            build_file(dense);
            foreach (file_bytes[k]) begin
                send_byte(file_bytes[k], 1'b0, '0);
                rand_sent++;
            end
        end
        push <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
